// File: rtl/core/line_steering_pid_with_obstacle_sequence_macros.svh
// assertion macro used by the steering datapath module
`ifndef LINE_STEERING_PID_WITH_OBSTACLE_SEQUENCE_MACROS_SVH
`define LINE_STEERING_PID_WITH_OBSTACLE_SEQUENCE_MACROS_SVH

// concurrent check on the rising clock, quiet during reset
`define LSP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// File: rtl/core/lsp_pkg.sv
// types and constants of the line steering controller
package lsp_pkg;

   localparam int TICK_W = 6;
   localparam int ERR_W  = 9;
   localparam int INT_W  = 26;
   localparam int OUT_W  = 24;
   localparam int PROD_W = 44;
   localparam int SUM_W  = 48;

   localparam logic signed [26:0] INTEG_LIMIT = 27'sd32768000;

   localparam logic [2:0] PHASE_TURN1    = 3'd0;
   localparam logic [2:0] PHASE_TURN2    = 3'd1;
   localparam logic [2:0] PHASE_STRAIGHT = 3'd2;
   localparam logic [2:0] PHASE_TURN3    = 3'd3;
   localparam logic [2:0] PHASE_TURN4    = 3'd4;

   localparam logic [2:0] REG_GAIN_P    = 3'd0;
   localparam logic [2:0] REG_GAIN_I    = 3'd1;
   localparam logic [2:0] REG_GAIN_D    = 3'd2;
   localparam logic [2:0] REG_STEP_TIME = 3'd3;
   localparam logic [2:0] REG_VIEW_MIN  = 3'd4;
   localparam logic [2:0] REG_VIEW_MAX  = 3'd5;

   typedef enum logic [1:0] {
      MUL_INC,
      MUL_P,
      MUL_D,
      MUL_I
   } mul_sel_type;

   typedef struct packed {
      logic        cap;
      logic        err;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        integ;
      logic        sum_init;
      logic        sum_add;
      logic        fin;
   } cmd_type;

endpackage

// File: rtl/core/lsp_ctrl.sv
// sequencer for one request: edge error, four multiplies, final update
module lsp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output lsp_pkg::cmd_type cmd
);
   import lsp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_ERR, S_MINC, S_MP, S_MD, S_MI, S_FIN
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = MUL_INC;
      unique case (state_ff)
         S_IDLE: cmd.cap = req_tvalid;
         S_ERR:  cmd.err = 1'b1;
         S_MINC: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_INC;
         end
         S_MP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_P;
            cmd.integ   = 1'b1;
         end
         S_MD: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_D;
            cmd.sum_init = 1'b1;
         end
         S_MI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_I;
            cmd.sum_add = 1'b1;
         end
         S_FIN:  cmd.fin = out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: if (req_tvalid) state_ff <= S_ERR;
            S_ERR:  state_ff <= S_MINC;
            S_MINC: state_ff <= S_MP;
            S_MP:   state_ff <= S_MD;
            S_MD:   state_ff <= S_MI;
            S_MI:   state_ff <= S_FIN;
            S_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/core/lsp_datapath.sv
// edge error, shared multiplier, integral, pid sum and obstacle sequence
`include "line_steering_pid_with_obstacle_sequence_macros.svh"
module lsp_datapath #(
   parameter int TURN_TICKS     = 10,
   parameter int STRAIGHT_TICKS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lsp_pkg::cmd_type     cmd,
   input  logic                 csr_we,
   input  logic [2:0]           csr_addr,
   input  logic [15:0]          csr_wdata,
   input  logic [6:0]           left_edge,
   input  logic [6:0]           right_edge,
   input  logic                 left_found,
   input  logic                 right_found,
   input  logic                 centre_valid,
   input  logic [6:0]           centre_line,
   input  logic                 obstacle_seen,
   input  logic                 force_valid,
   input  logic signed [23:0]   force_value,
   output logic signed [23:0]   steer_out,
   output logic                 turn_left,
   output logic                 obstacle_active,
   output logic [2:0]           obstacle_phase
);
   import lsp_pkg::*;

   localparam logic [TICK_W-1:0] TURN_N     = TICK_W'(TURN_TICKS);
   localparam logic [TICK_W-1:0] TURN_LAST  = TICK_W'(TURN_TICKS + 1);
   localparam logic [TICK_W-1:0] STRAIGHT_N = TICK_W'(STRAIGHT_TICKS);

   // configuration
   logic [15:0] gain_p_ff, gain_i_ff, gain_d_ff, step_time_ff;
   logic [6:0]  view_min_ff, view_max_ff;

   // captured request
   logic [6:0]  l_ff, r_ff, cl_ff;
   logic        lf_ff, rf_ff, cv_ff, obs_ff, fv_ff;
   logic signed [23:0] fval_ff;

   // state
   logic [6:0]               half_ff;
   logic signed [ERR_W-1:0]  err_prev_ff;
   logic signed [INT_W-1:0]  integ_ff;
   logic signed [OUT_W-1:0]  hold_ff, saved_ff;
   logic                     busy_ff;
   logic [2:0]               phase_ff;
   logic [TICK_W-1:0]        ticks_ff;

   // working registers
   logic signed [ERR_W-1:0]  e_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [OUT_W-1:0] out_steer_ff;
   logic                     out_busy_ff;
   logic [2:0]               out_phase_ff;

   // edge error
   logic signed [9:0] lv, rv, view, half_s, hv_s, e_calc;
   logic [6:0]        half_new;
   logic              both;

   always_comb begin
      both = lf_ff && rf_ff;
      lv   = 10'sd63 - $signed({3'b0, l_ff});
      rv   = $signed({3'b0, r_ff}) - 10'sd64;
      view = $signed({3'b0, r_ff}) - $signed({3'b0, l_ff});
      priority if (view >= $signed({3'b0, view_max_ff})) begin
         half_new = {1'b0, view_max_ff[6:1]};
      end else if (view <= $signed({3'b0, view_min_ff})) begin
         half_new = {1'b0, view_min_ff[6:1]};
      end else begin
         half_new = {1'b0, view[6:1]};
      end
      half_s = $signed({3'b0, half_new});
      hv_s   = $signed({3'b0, half_ff});
      priority if (both) begin
         priority if (lv <= half_s)      e_calc = lv - half_s;
         else if (rv <= half_s)          e_calc = half_s - rv;
         else                            e_calc = '0;
      end else if (lf_ff) begin
         e_calc = lv - hv_s;
      end else if (rf_ff) begin
         e_calc = hv_s - rv;
      end else begin
         e_calc = '0;
      end
   end

   // error seen by the pid, centre line wins when valid
   logic signed [ERR_W-1:0] e_pid;
   logic signed [ERR_W:0]   e_diff;
   assign e_pid  = cv_ff ? ERR_W'(10'sd64 - $signed({3'b0, cl_ff})) : e_ff;
   assign e_diff = {e_pid[ERR_W-1], e_pid} - {err_prev_ff[ERR_W-1], err_prev_ff};

   // shared multiplier
   logic signed [26:0] mul_a;
   logic [15:0]        mul_b;
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_INC: begin mul_a = 27'(e_ff);   mul_b = step_time_ff; end
         MUL_P:   begin mul_a = 27'(e_pid);  mul_b = gain_p_ff;    end
         MUL_D:   begin mul_a = 27'(e_diff); mul_b = gain_d_ff;    end
         MUL_I:   begin mul_a = 27'(integ_ff); mul_b = gain_i_ff;  end
         default: begin mul_a = '0;          mul_b = '0;           end
      endcase
   end

   logic signed [PROD_W-1:0] mul_prod;
   assign mul_prod = mul_a * $signed({1'b0, mul_b});

   // integral with anti-windup
   logic signed [26:0] acc;
   assign acc = 27'(integ_ff) + prod_ff[26:0];

   // pid result, arithmetic shift floors
   logic signed [SUM_W-1:0] sum_fin;
   logic signed [OUT_W-1:0] pid_out;
   assign sum_fin = sum_ff + SUM_W'(prod_ff);
   assign pid_out = sum_fin[SUM_W-1:24];

   logic signed [OUT_W-1:0] neg_saved;
   assign neg_saved = (saved_ff == {1'b1, {(OUT_W-1){1'b0}}}) ?
                      {1'b0, {(OUT_W-1){1'b1}}} : -saved_ff;

   logic                    blk;
   logic signed [OUT_W-1:0] hold_n, hold_q, saved_q;
   logic                    busy_q;
   logic [2:0]              phase_q;
   logic [TICK_W-1:0]       ticks_q;

   always_comb begin
      blk = busy_ff || obs_ff;
      priority if (fv_ff) hold_n = fval_ff;
      else if (!blk)      hold_n = pid_out;
      else                hold_n = hold_ff;
      hold_q  = hold_n;
      saved_q = saved_ff;
      busy_q  = busy_ff;
      phase_q = phase_ff;
      ticks_q = ticks_ff;
      if (blk) begin
         busy_q = 1'b1;
         unique case (phase_ff)
            PHASE_TURN1: begin
               if (ticks_ff != '0) begin
                  saved_q = hold_n;
                  ticks_q = ticks_ff - 1'b1;
               end else begin
                  phase_q = PHASE_TURN2;
                  ticks_q = TURN_N;
               end
            end
            PHASE_TURN2: begin
               if (ticks_ff != '0) begin
                  hold_q  = neg_saved;
                  ticks_q = ticks_ff - 1'b1;
               end else begin
                  phase_q = PHASE_STRAIGHT;
                  ticks_q = STRAIGHT_N;
               end
            end
            PHASE_STRAIGHT: begin
               if (ticks_ff != '0) begin
                  hold_q  = '0;
                  ticks_q = ticks_ff - 1'b1;
               end else begin
                  phase_q = PHASE_TURN3;
                  ticks_q = TURN_N;
               end
            end
            PHASE_TURN3: begin
               if (ticks_ff != '0) begin
                  hold_q  = neg_saved;
                  ticks_q = ticks_ff - 1'b1;
               end else begin
                  phase_q = PHASE_TURN4;
                  ticks_q = TURN_LAST;
               end
            end
            PHASE_TURN4: begin
               if (ticks_ff != '0) begin
                  hold_q  = saved_ff;
                  ticks_q = ticks_ff - 1'b1;
               end else begin
                  phase_q = PHASE_TURN1;
                  ticks_q = TURN_N;
                  busy_q  = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= 16'd14592;
         gain_i_ff    <= 16'd0;
         gain_d_ff    <= 16'd65535;
         step_time_ff <= 16'd328;
         view_min_ff  <= 7'd20;
         view_max_ff  <= 7'd100;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_GAIN_P:    gain_p_ff    <= csr_wdata;
            REG_GAIN_I:    gain_i_ff    <= csr_wdata;
            REG_GAIN_D:    gain_d_ff    <= csr_wdata;
            REG_STEP_TIME: step_time_ff <= csr_wdata;
            REG_VIEW_MIN:  view_min_ff  <= csr_wdata[6:0];
            REG_VIEW_MAX:  view_max_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         l_ff    <= left_edge;
         r_ff    <= right_edge;
         lf_ff   <= left_found;
         rf_ff   <= right_found;
         cv_ff   <= centre_valid;
         cl_ff   <= centre_line;
         obs_ff  <= obstacle_seen;
         fv_ff   <= force_valid;
         fval_ff <= force_value;
      end
      if (cmd.err) e_ff <= e_calc[ERR_W-1:0];
      if (cmd.mul_en) prod_ff <= mul_prod;
      if (cmd.sum_init) sum_ff <= SUM_W'($signed(prod_ff[29:0])) <<< 16;
      if (cmd.sum_add)  sum_ff <= sum_ff + (SUM_W'($signed(prod_ff[29:0])) <<< 16);
      if (cmd.fin) begin
         out_steer_ff <= hold_q;
         out_busy_ff  <= busy_q;
         out_phase_ff <= phase_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff     <= '0;
         err_prev_ff <= '0;
         integ_ff    <= '0;
         hold_ff     <= '0;
         saved_ff    <= '0;
         busy_ff     <= 1'b0;
         phase_ff    <= PHASE_TURN1;
         ticks_ff    <= TURN_N;
      end else begin
         if (cmd.err && !fv_ff && both) half_ff <= half_new;
         // step that reaches the limit is dropped
         if (cmd.integ && !fv_ff && acc < INTEG_LIMIT && acc > -INTEG_LIMIT) begin
            integ_ff <= acc[INT_W-1:0];
         end
         if (cmd.fin) begin
            if (!fv_ff && !blk) err_prev_ff <= e_pid;
            hold_ff  <= hold_q;
            saved_ff <= saved_q;
            busy_ff  <= busy_q;
            phase_ff <= phase_q;
            ticks_ff <= ticks_q;
         end
      end
   end

   assign steer_out       = out_steer_ff;
   assign turn_left       = (out_steer_ff > 0);
   assign obstacle_active = out_busy_ff;
   assign obstacle_phase  = out_phase_ff;

   `LSP_ASSERT(a_phase_range, phase_ff <= PHASE_TURN4, "phase code out of range")
   `LSP_ASSERT(a_idle_phase, !busy_ff |-> (phase_ff == PHASE_TURN1), "idle sequence not in first phase")
   `LSP_ASSERT(a_integ_bound, (27'(integ_ff) < INTEG_LIMIT) && (27'(integ_ff) > -INTEG_LIMIT), "integral beyond limit")
   `LSP_ASSERT(a_busy_start, (cmd.fin && obs_ff) |=> busy_ff || (phase_ff == PHASE_TURN1), "obstacle did not start sequence")

endmodule

// File: rtl/core/line_steering_pid_with_obstacle_sequence.sv
// top level of the line steering pid controller with obstacle turn sequence
// Each request is one control tick and returns exactly one result. A request passes through
// the edge error step, then four multiplies through a single shared 27x17 multiplier
// (integral step, proportional, derivative, integral terms), then a final step that closes
// the pid sum and steps the obstacle sequence. One tick is worked on at a time, so a new
// request is accepted only once the previous one is through; the next request is
// accepted while the previous result still waits on rsp. Configuration writes go through
// csr_we/csr_addr/csr_wdata by the user only while the block is idle (not enforced).
module line_steering_pid_with_obstacle_sequence #(
   parameter int TURN_TICKS     = 10,
   parameter int STRAIGHT_TICKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // left_edge[6:0], right_edge[13:7], left_found[14], right_found[15],
   // centre_valid[16], centre_line[23:17], obstacle_seen[24], force_valid[25],
   // force_value[49:26], zero fill
   input  logic [55:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // steer_out[23:0], turn_left[24], obstacle_active[25], obstacle_phase[28:26], zero fill
   output logic [31:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import lsp_pkg::*;

   cmd_type            cmd;
   logic signed [23:0] steer_out;
   logic               turn_left, obstacle_active;
   logic [2:0]         obstacle_phase;

   lsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lsp_datapath #(
      .TURN_TICKS     (TURN_TICKS),
      .STRAIGHT_TICKS (STRAIGHT_TICKS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .left_edge       (req_tdata[6:0]),
      .right_edge      (req_tdata[13:7]),
      .left_found      (req_tdata[14]),
      .right_found     (req_tdata[15]),
      .centre_valid    (req_tdata[16]),
      .centre_line     (req_tdata[23:17]),
      .obstacle_seen   (req_tdata[24]),
      .force_valid     (req_tdata[25]),
      .force_value     ($signed(req_tdata[49:26])),
      .steer_out       (steer_out),
      .turn_left       (turn_left),
      .obstacle_active (obstacle_active),
      .obstacle_phase  (obstacle_phase)
   );

   assign rsp_tdata = {3'b000, obstacle_phase, obstacle_active, turn_left, steer_out};

endmodule
